@@ rtl/core/box_constrained_babai_estimate_top_defines.svh @@
// Assertion macros shared by the Babai estimator RTL.
`ifndef BOX_CONSTRAINED_BABAI_ESTIMATE_TOP_DEFINES_SVH
`define BOX_CONSTRAINED_BABAI_ESTIMATE_TOP_DEFINES_SVH

// Concurrent check that is switched off while reset is asserted.
`define BCBE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also holds while reset is asserted.
`define BCBE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/bcbe_pkg.sv @@
// Shared types and constants of the Babai estimator.
package bcbe_pkg;

    localparam int MATRIX_SIZE_DEF = 16;
    localparam int RUN_LIMIT       = 16;
    localparam int VALUE_W         = 32;
    localparam int EST_W           = 16;
    localparam int ROW_W           = 4;
    localparam int ACC_W           = 64;
    localparam int PROD_W          = 48;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_MATRIX = 2'd0;
    localparam kind_t KIND_TARGET = 2'd1;
    localparam kind_t KIND_START  = 2'd2;

    typedef logic [1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_ACTIVE_SIZE = 2'd0;
    localparam cfg_idx_t CFG_CONSTRAINED = 2'd1;
    localparam cfg_idx_t CFG_UPPER_BOUND = 2'd2;

    // Estimate travelling down the chain of row cells.
    typedef struct packed {
        logic             valid;
        logic [EST_W-1:0] z;
    } token_t;

    // Divider status towards the sequencer.
    typedef struct packed {
        logic             done;
        logic [EST_W-1:0] quot;
    } div_res_t;

endpackage

@@ rtl/core/box_constrained_babai_estimate_top.sv @@
// Box-constrained Babai nearest-plane estimator over signed Q16.16 data.
// Input stream (s_*): tuser carries the kind of each transaction. A matrix load
// writes R[row][col] of the upper triangle, a target load writes y_bar[row]; each
// load is a single transaction. A start transaction runs back substitution over the
// first n rows, n being active_size limited to 1..min(MATRIX_SIZE, 16).
// Output stream (m_*): one transaction per row from row n-1 down to row 0, with
// tlast on row zero. Each row fetches the diagonal from the triangle RAM, runs
// the bit-serial divider and issues the result; for all rows but row zero the
// estimate then walks down the chain of row cells, one cell a cycle, each cell
// subtracting its product. The input is not ready while a run is in progress.
// A stalled receiver holds the result in the output register and the run waits
// until that register is free.
// Reset returns the configuration registers to their defaults (n = 16, constrained,
// upper bound 7) and empties the output register; the stores need loading first.
// Configuration writes are taken at any cycle and must only be made while idle.
`include "box_constrained_babai_estimate_top_defines.svh"

module box_constrained_babai_estimate_top #(
    parameter int MATRIX_SIZE = bcbe_pkg::MATRIX_SIZE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // row[3:0], col[7:4], value[39:8]
    input  logic [1:0]  s_tuser,    // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // row_index[3:0], estimate[19:4], zero fill[23:20]
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [14:0] cfg_wdata
);

    localparam int TriDepth = MATRIX_SIZE * (MATRIX_SIZE + 1) / 2;
    localparam int AW       = $clog2(TriDepth);
    localparam int Cells    = (MATRIX_SIZE < bcbe_pkg::RUN_LIMIT) ? MATRIX_SIZE
                                                                  : bcbe_pkg::RUN_LIMIT;
    localparam int IW       = $clog2(Cells);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIAG  = 6'b000010,
        S_DWAIT = 6'b000100,
        S_DIV   = 6'b001000,
        S_EMIT  = 6'b010000,
        S_WALK  = 6'b100000
    } state_t;

    state_t               state_reg, state_next;
    logic [4:0]           as_reg;
    logic                 cm_reg;
    logic [14:0]          ub_reg;
    logic [IW-1:0]        i_reg;
    logic [4:0]           wcnt_reg;
    logic [15:0]          z_reg;
    logic [15:0]          est_reg;
    logic                 m_tvalid_reg;
    logic [3:0]           m_row_reg;
    logic [15:0]          m_est_reg;
    logic                 m_last_reg;

    logic [3:0]           in_row;
    logic [3:0]           in_col;
    logic [31:0]          in_value;
    logic                 s_hs;
    logic                 start_hs;
    logic                 mat_we;
    logic [IW-1:0]        n_m1;
    logic [IW-1:0]        k_row;
    logic [AW-1:0]        waddr;
    logic [AW-1:0]        raddr;
    logic [31:0]          rdata;
    logic                 out_load;
    logic                 walk_start;
    logic [15:0]          est_clamped;
    bcbe_pkg::div_res_t   div_res;
    bcbe_pkg::token_t     inj_tok;
    bcbe_pkg::token_t     tok_out [Cells];
    logic [63:0]          acc_arr [Cells];

    function automatic logic [AW-1:0] tri_addr(input logic [3:0] r, input logic [3:0] c);
        int ri;
        int ci;
        ri = int'(r);
        ci = int'(c);
        return AW'(ri * MATRIX_SIZE - ((ri * (ri - 1)) >> 1) + (ci - ri));
    endfunction

    assign in_row   = s_tdata[3:0];
    assign in_col   = s_tdata[7:4];
    assign in_value = s_tdata[39:8];
    assign s_tready = (state_reg == S_IDLE);
    assign s_hs     = s_tvalid && s_tready;
    assign start_hs = s_hs && (s_tuser == bcbe_pkg::KIND_START);
    assign mat_we   = s_hs && (s_tuser == bcbe_pkg::KIND_MATRIX)
                      && (int'(in_row) < MATRIX_SIZE) && (int'(in_col) < MATRIX_SIZE)
                      && (in_col >= in_row);

    always_comb
    begin
        if (as_reg == 5'd0)
        begin
            n_m1 = '0;
        end
        else if (int'(as_reg) > Cells)
        begin
            n_m1 = IW'(Cells - 1);
        end
        else
        begin
            n_m1 = IW'(as_reg - 5'd1);
        end
    end

    assign k_row = IW'(int'(i_reg) - 1 - int'(wcnt_reg));
    assign waddr = tri_addr(in_row, in_col);
    assign raddr = (state_reg == S_WALK) ? tri_addr(4'(k_row), 4'(i_reg))
                                         : tri_addr(4'(i_reg), 4'(i_reg));

    bcbe_ram #(
        .WIDTH (bcbe_pkg::VALUE_W),
        .DEPTH (TriDepth)
    ) u_tri_ram (
        .clk   (clk),
        .we    (mat_we),
        .waddr (waddr),
        .wdata (in_value),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign walk_start    = (state_reg == S_WALK) && (wcnt_reg == 5'd0);
    assign inj_tok.valid = 1'b1;
    assign inj_tok.z     = z_reg;

    for (genvar g = 0; g < Cells; g++)
    begin : g_cell
        bcbe_pkg::token_t tok_up;
        if (g == Cells - 1)
        begin : g_end
            assign tok_up = '0;
        end
        else
        begin : g_mid
            assign tok_up = tok_out[g + 1];
        end

        bcbe_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .load_en    (s_hs && (s_tuser == bcbe_pkg::KIND_TARGET) && (int'(in_row) == g)),
            .load_value (in_value),
            .init       (start_hs),
            .inject     (walk_start && (int'(k_row) == g)),
            .inj_tok    (inj_tok),
            .tok_in     (tok_up),
            .r_data     (rdata),
            .tok_out    (tok_out[g]),
            .acc        (acc_arr[g])
        );
    end

    bcbe_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_DWAIT),
        .num   (acc_arr[i_reg]),
        .den   (rdata),
        .res   (div_res)
    );

    always_comb
    begin
        est_clamped = div_res.quot;
        if (cm_reg)
        begin
            if (div_res.quot[15])
            begin
                est_clamped = '0;
            end
            else if ($signed(div_res.quot) > $signed({1'b0, ub_reg}))
            begin
                est_clamped = {1'b0, ub_reg};
            end
        end
    end

    assign out_load = (state_reg == S_EMIT) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (start_hs) state_next = S_DIAG;
            S_DIAG:  state_next = S_DWAIT;
            S_DWAIT: state_next = S_DIV;
            S_DIV:   if (div_res.done) state_next = S_EMIT;
            S_EMIT:
            begin
                if (out_load)
                begin
                    state_next = (i_reg == '0) ? S_IDLE : S_WALK;
                end
            end
            S_WALK:
            begin
                if (int'(wcnt_reg) == int'(i_reg) + 1)
                begin
                    state_next = S_DIAG;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            as_reg       <= 5'd16;
            cm_reg       <= 1'b1;
            ub_reg       <= 15'd7;
            m_tvalid_reg <= 1'b0;
            i_reg        <= '0;
            wcnt_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    bcbe_pkg::CFG_ACTIVE_SIZE: as_reg <= cfg_wdata[4:0];
                    bcbe_pkg::CFG_CONSTRAINED: cm_reg <= cfg_wdata[0];
                    bcbe_pkg::CFG_UPPER_BOUND: ub_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            if (start_hs)
            begin
                i_reg <= n_m1;
            end
            else if ((state_reg == S_WALK) && (state_next == S_DIAG))
            begin
                i_reg <= i_reg - IW'(1);
            end
            if (state_reg == S_WALK)
            begin
                wcnt_reg <= wcnt_reg + 5'd1;
            end
            else
            begin
                wcnt_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_DIV) && div_res.done)
        begin
            est_reg <= est_clamped;
        end
        if (out_load)
        begin
            m_row_reg  <= 4'(i_reg);
            m_est_reg  <= est_reg;
            m_last_reg <= (i_reg == '0);
            z_reg      <= est_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, m_est_reg, m_row_reg};
    assign m_tlast  = m_last_reg;

    `BCBE_ASSERT(a_done_in_div, clk, rst_n, div_res.done |-> (state_reg == S_DIV), "divider finished outside the divide state")
    `BCBE_ASSERT(a_start_row, clk, rst_n, start_hs |=> (i_reg == $past(n_m1)), "run did not begin at the last active row")
    `BCBE_ASSERT(a_last_idle, clk, rst_n, (out_load && (i_reg == '0)) |=> (state_reg == S_IDLE), "run continued after row zero")
    `BCBE_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> (!m_tvalid && (state_reg == S_IDLE)), "output or sequencer active in reset")

endmodule

@@ rtl/core/bcbe_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bcbe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 136
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/bcbe_cell.sv @@
// One row cell: holds the target word and the running residual of its row.
module bcbe_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load_en,
    input  logic [31:0]          load_value,
    input  logic                 init,
    input  logic                 inject,
    input  bcbe_pkg::token_t     inj_tok,
    input  bcbe_pkg::token_t     tok_in,
    input  logic [31:0]          r_data,
    output bcbe_pkg::token_t     tok_out,
    output logic [63:0]          acc
);

    bcbe_pkg::token_t  tok_reg;
    bcbe_pkg::token_t  tok_next;
    logic              prod_valid_reg;
    logic [31:0]       target_reg;
    logic signed [47:0] prod_reg;
    logic signed [63:0] acc_reg;

    assign tok_next = inject ? inj_tok : tok_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg        <= '0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            tok_reg        <= tok_next;
            prod_valid_reg <= tok_reg.valid;
        end
    end

    // The matrix word arrives on the shared read bus in the cycle the token sits here.
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            target_reg <= load_value;
        end
        if (tok_reg.valid)
        begin
            prod_reg <= $signed(r_data) * $signed(tok_reg.z);
        end
        if (init)
        begin
            acc_reg <= {{32{target_reg[31]}}, target_reg};
        end
        else if (prod_valid_reg)
        begin
            acc_reg <= acc_reg - {{16{prod_reg[47]}}, prod_reg};
        end
    end

    assign tok_out = tok_reg;
    assign acc     = acc_reg;

endmodule

@@ rtl/core/bcbe_div.sv @@
// Rounding divider: residual over diagonal, one quotient bit per cycle, saturated to 16 bits.
module bcbe_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [63:0]         num,
    input  logic [31:0]         den,
    output bcbe_pkg::div_res_t  res
);

    typedef enum logic [4:0] {
        D_IDLE = 5'b00001,
        D_PREP = 5'b00010,
        D_CHK  = 5'b00100,
        D_ITER = 5'b01000,
        D_FIN  = 5'b10000
    } dstate_t;

    dstate_t     state_reg, state_next;
    logic [4:0]  cnt_reg;
    logic        done_reg;
    logic [63:0] an_reg;
    logic [31:0] ad_reg;
    logic        neg_reg;
    logic        dz_reg;
    logic        nz_reg;
    logic        npos_reg;
    logic [65:0] num2_reg;
    logic [49:0] rem_reg;
    logic [48:0] dsh_reg;
    logic [16:0] q_reg;
    logic [15:0] qout_reg;
    logic [16:0] q_neg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            D_IDLE: if (start) state_next = D_PREP;
            D_PREP: state_next = D_CHK;
            D_CHK:
            begin
                if (dz_reg || (num2_reg >= {16'd0, ad_reg, 18'd0}))
                begin
                    state_next = D_IDLE;
                end
                else
                begin
                    state_next = D_ITER;
                end
            end
            D_ITER: if (cnt_reg == 5'd0) state_next = D_FIN;
            D_FIN:  state_next = D_IDLE;
            default: state_next = D_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= ((state_reg == D_CHK) && (state_next == D_IDLE))
                         || (state_reg == D_FIN);
        end
    end

    assign q_neg = ~q_reg + 17'd1;

    // Rounded quotient is floor((2|n| + |d|) / (2|d|)); anything from 2^17 up saturates.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            D_IDLE:
            begin
                an_reg   <= num[63] ? (64'd0 - num) : num;
                ad_reg   <= den[31] ? (32'd0 - den) : den;
                neg_reg  <= num[63] ^ den[31];
                dz_reg   <= (den == 32'd0);
                nz_reg   <= (num == 64'd0);
                npos_reg <= !num[63];
            end
            D_PREP:
            begin
                num2_reg <= {1'b0, an_reg, 1'b0} + {34'd0, ad_reg};
                dsh_reg  <= {ad_reg, 17'd0};
                q_reg    <= '0;
                cnt_reg  <= 5'd16;
            end
            D_CHK:
            begin
                rem_reg <= num2_reg[49:0];
                if (dz_reg)
                begin
                    qout_reg <= nz_reg ? 16'sd0 : (npos_reg ? 16'h7FFF : 16'h8000);
                end
                else
                begin
                    qout_reg <= neg_reg ? 16'h8000 : 16'h7FFF;
                end
            end
            D_ITER:
            begin
                if (rem_reg >= {1'b0, dsh_reg})
                begin
                    rem_reg        <= rem_reg - {1'b0, dsh_reg};
                    q_reg[cnt_reg] <= 1'b1;
                end
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= cnt_reg - 5'd1;
            end
            D_FIN:
            begin
                if (neg_reg)
                begin
                    qout_reg <= (q_reg > 17'd32768) ? 16'h8000 : q_neg[15:0];
                end
                else
                begin
                    qout_reg <= (q_reg > 17'd32767) ? 16'h7FFF : q_reg[15:0];
                end
            end
            default: ;
        endcase
    end

    assign res.done = done_reg;
    assign res.quot = qout_reg;

endmodule
